/* rtl/hia_pkg.sv */
// ----------------------------------------------------------------------------
// hia_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the hierarchical id allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hia_pkg;

  localparam int TREE_LEVELS   = 4;
  localparam int ID_BITS_DEF   = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_REPLACE = 2'd1;
  localparam logic [1:0] KIND_GET     = 2'd2;

  typedef struct packed {
    logic clear;
    logic start;
    logic top;
    logic walk_rd;
    logic walk_wt;
    logic path_rd;
    logic path_wt;
    logic store;
    logic mark;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       clr_last;
    logic       top_full;
    logic       lv_zero;
    logic       used;
    logic       mark_more;
    logic       rsp_busy;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/hierarchical_id_allocator.sv */
// ----------------------------------------------------------------------------
// hierarchical_id_allocator
// Four-level bitmap radix tree that allocates the lowest free id, replaces
// or reads the data word at a given id. After reset a clearing pass zeroes
// the bitmaps; requests are stalled meanwhile. One request is processed at
// a time. An insert does one bitmap read per level on the way down, a slot
// write, then one bitmap write per level up to the first word that does
// not become full, and skips all of these when the tree is already full;
// a get and a replace read the path words, and a replace then writes the
// slot and, on an unused slot, the bitmaps. The bitmap RAMs each have a
// single read and write port. A finished result sits in an output register,
// so the next request is taken while it waits; a result still stalled when
// the next one finishes holds the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_id_allocator #(
  parameter int ID_BITS   = hia_pkg::ID_BITS_DEF,
  parameter int DATA_BITS = hia_pkg::DATA_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [1:0]           kind,
  input  wire logic [ID_BITS-1:0]   id,
  input  wire logic [DATA_BITS-1:0] data_in,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [ID_BITS-1:0]        new_id,
  output logic [DATA_BITS-1:0]      data_out,
  output logic                      found,
  output logic                      status
);

  import hia_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hia_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .kind(kind), .sts(sts), .cmd(cmd)
  );

  hia_dp #(.ID_BITS(ID_BITS), .DATA_BITS(DATA_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .kind(kind), .id(id),
    .data_in(data_in), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .new_id(new_id), .data_out(data_out), .found(found), .status(status)
  );

endmodule

`default_nettype wire

/* rtl/hia_ram.sv */
// ----------------------------------------------------------------------------
// hia_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hia_ram #(
  parameter int WIDTH     = 32,
  parameter int ADDR_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/hia_ctrl.sv */
// ----------------------------------------------------------------------------
// hia_ctrl
// Sequencer: clearing pass, tree walk, path read, slot store, fullness
// propagation and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module hia_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire logic [1:0]    kind,
  input  wire hia_pkg::sts_t sts,
  output hia_pkg::cmd_t      cmd
);

  import hia_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_TOP   = 10'b0000000100,
    S_WRD   = 10'b0000001000,
    S_WWT   = 10'b0000010000,
    S_PRD   = 10'b0000100000,
    S_PWT   = 10'b0001000000,
    S_STORE = 10'b0010000000,
    S_MARK  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          case (kind)
            KIND_INSERT:            state_next = S_TOP;
            KIND_REPLACE, KIND_GET: state_next = S_PRD;
            default:                state_next = S_FIN;
          endcase
        end
      end
      S_TOP: begin
        cmd.top    = 1'b1;
        state_next = sts.top_full ? S_FIN : S_WRD;
      end
      S_WRD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_WWT;
      end
      S_WWT: begin
        cmd.walk_wt = 1'b1;
        state_next  = sts.lv_zero ? S_STORE : S_WRD;
      end
      S_PRD: begin
        cmd.path_rd = 1'b1;
        state_next  = S_PWT;
      end
      S_PWT: begin
        cmd.path_wt = 1'b1;
        state_next  = (sts.kind == KIND_GET) ? S_FIN : S_STORE;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = (sts.kind == KIND_REPLACE && sts.used) ? S_FIN : S_MARK;
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = sts.mark_more ? S_MARK : S_FIN;
      end
      S_FIN: begin
        if (!sts.rsp_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/hia_dp.sv */
// ----------------------------------------------------------------------------
// hia_dp
// Datapath: bitmap RAMs per level, top bitmap register, slot data RAM,
// walk prefix, saved path words and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hia_dp #(
  parameter int ID_BITS   = hia_pkg::ID_BITS_DEF,
  parameter int DATA_BITS = hia_pkg::DATA_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hia_pkg::cmd_t        cmd,
  output hia_pkg::sts_t             sts,
  input  wire logic [1:0]           kind,
  input  wire logic [ID_BITS-1:0]   id,
  input  wire logic [DATA_BITS-1:0] data_in,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [ID_BITS-1:0]        new_id,
  output logic [DATA_BITS-1:0]      data_out,
  output logic                      found,
  output logic                      status
);

  import hia_pkg::*;

  localparam int LB     = ID_BITS / TREE_LEVELS;
  localparam int FANOUT = 1 << LB;
  localparam int AW0    = ID_BITS - LB;
  localparam int AW1    = ID_BITS - 2 * LB;
  localparam int AW2    = ID_BITS - 3 * LB;
  localparam int LVW    = $clog2(TREE_LEVELS);
  localparam logic [LVW-1:0] LV_TOP = LVW'(TREE_LEVELS - 1);

  logic [1:0]           kind_q;
  logic [DATA_BITS-1:0] data_q;
  logic [ID_BITS-1:0]   prefix;
  logic [LVW-1:0]       lv;
  logic [FANOUT-1:0]    word_q [TREE_LEVELS];
  logic [FANOUT-1:0]    top_q;
  logic                 used_q, found_q, status_q;
  logic [DATA_BITS-1:0] data_out_q;
  logic [AW0-1:0]       clr_cnt;

  logic [FANOUT-1:0]    rd_word [TREE_LEVELS];
  logic [FANOUT-1:0]    mark_word;
  logic [FANOUT-1:0]    wdata;
  logic [DATA_BITS-1:0] slot_rd;
  logic [AW0-1:0]       raddr0, waddr0;
  logic [AW1-1:0]       raddr1, waddr1;
  logic [AW2-1:0]       raddr2, waddr2;
  logic                 we0, we1, we2;

  function automatic logic [LB-1:0] first_zero(input logic [FANOUT-1:0] w);
    logic [LB-1:0] b;
    b = LB'(FANOUT - 1);
    for (int i = FANOUT - 2; i >= 0; i--) begin
      if (!w[i]) b = LB'(i);
    end
    return b;
  endfunction

  assign mark_word = word_q[lv] | (FANOUT'(1) << prefix[lv*LB +: LB]);
  assign wdata     = cmd.clear ? '0 : mark_word;

  assign raddr0 = cmd.path_rd ? prefix[ID_BITS-1:LB]   : prefix[AW0-1:0];
  assign raddr1 = cmd.path_rd ? prefix[ID_BITS-1:2*LB] : prefix[AW1-1:0];
  assign raddr2 = cmd.path_rd ? prefix[ID_BITS-1:3*LB] : prefix[AW2-1:0];
  assign waddr0 = cmd.clear ? clr_cnt              : prefix[ID_BITS-1:LB];
  assign waddr1 = cmd.clear ? clr_cnt[AW1-1:0]     : prefix[ID_BITS-1:2*LB];
  assign waddr2 = cmd.clear ? clr_cnt[AW2-1:0]     : prefix[ID_BITS-1:3*LB];
  assign we0    = cmd.clear | (cmd.mark && lv == LVW'(0));
  assign we1    = cmd.clear | (cmd.mark && lv == LVW'(1));
  assign we2    = cmd.clear | (cmd.mark && lv == LVW'(2));
  assign rd_word[TREE_LEVELS-1] = top_q;

  hia_ram #(.WIDTH(FANOUT), .ADDR_BITS(AW0)) u_lvl0 (
    .clk(clk), .we(we0), .waddr(waddr0), .wdata(wdata), .raddr(raddr0), .rdata(rd_word[0])
  );
  hia_ram #(.WIDTH(FANOUT), .ADDR_BITS(AW1)) u_lvl1 (
    .clk(clk), .we(we1), .waddr(waddr1), .wdata(wdata), .raddr(raddr1), .rdata(rd_word[1])
  );
  hia_ram #(.WIDTH(FANOUT), .ADDR_BITS(AW2)) u_lvl2 (
    .clk(clk), .we(we2), .waddr(waddr2), .wdata(wdata), .raddr(raddr2), .rdata(rd_word[2])
  );
  hia_ram #(.WIDTH(DATA_BITS), .ADDR_BITS(ID_BITS)) u_slot (
    .clk(clk), .we(cmd.store), .waddr(prefix), .wdata(data_q), .raddr(prefix),
    .rdata(slot_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top_q     <= '0;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.mark && lv == LV_TOP) top_q <= mark_word;
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_q     <= kind;
      data_q     <= data_in;
      prefix     <= id;
      used_q     <= 1'b0;
      found_q    <= 1'b0;
      status_q   <= 1'b0;
      data_out_q <= '0;
    end
    if (cmd.top) begin
      if (&top_q) begin
        status_q <= 1'b1;
      end else begin
        prefix <= ID_BITS'(first_zero(top_q));
      end
      word_q[TREE_LEVELS-1] <= top_q;
      lv <= LV_TOP - 1'b1;
    end
    if (cmd.walk_wt) begin
      word_q[lv] <= rd_word[lv];
      prefix     <= {prefix[ID_BITS-LB-1:0], first_zero(rd_word[lv])};
      lv         <= lv - 1'b1;
    end
    if (cmd.path_wt) begin
      for (int k = 0; k < TREE_LEVELS; k++) begin
        word_q[k] <= rd_word[k];
      end
      used_q     <= rd_word[0][prefix[LB-1:0]];
      found_q    <= rd_word[0][prefix[LB-1:0]];
      data_out_q <= rd_word[0][prefix[LB-1:0]] ? slot_rd : '0;
    end
    if (cmd.store) lv <= '0;
    if (cmd.mark) lv <= lv + 1'b1;
    if (cmd.load) begin
      new_id   <= prefix;
      data_out <= data_out_q;
      found    <= found_q;
      status   <= status_q;
    end
  end

  always_comb begin
    sts           = '0;
    sts.kind      = kind_q;
    sts.clr_last  = &clr_cnt;
    sts.top_full  = &top_q;
    sts.lv_zero   = (lv == '0);
    sts.used      = used_q;
    sts.mark_more = (&mark_word) && (lv != LV_TOP);
    sts.rsp_busy  = rsp_valid & rsp_stall;
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(rsp_valid && rsp_stall))
    else $error("result loaded over a pending transfer");
  a_status_insert: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && status_q) |-> (kind_q == KIND_INSERT))
    else $error("full status on a non-insert operation");
  a_found_used: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && found_q) |-> used_q)
    else $error("found without a used slot");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hierarchical id allocator. A directed table is
// followed by random inserts, replaces, gets and unknown operations, then a
// closing burst without idling or receiver stalls. Every response is checked
// against the table row for typed rows, else a bitmap-tree predictor kept here.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hia_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_FULL = 1'b1;
  localparam int N_RANDOM = 1830;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [15:0] new_id;
    logic [31:0] data_out;
    logic        found;
    logic        status;
  } rsp_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [31:0] data;
    bit          typed;
    rsp_t        rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] kind = KIND_GET;
  logic [15:0] id = '0;
  logic [31:0] data_in = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [15:0] new_id;
  logic [31:0] data_out;
  logic found;
  logic status;

  // predictor state
  logic [31:0] slot_word [65536];
  logic [15:0] used_map [4096];
  logic [15:0] l1_map [256];
  logic [15:0] l2_map [16];
  logic [15:0] top_map;

  rsp_t pending_rsp [$];
  int errors = 0;
  int n_sent = 0, n_rcvd = 0, n_full = 0, n_hits = 0;
  longint cycles = 0;
  bit fast = 1'b0;
  int stall_mode = 0;

  hierarchical_id_allocator u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .kind(kind), .id(id), .data_in(data_in),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .new_id(new_id), .data_out(data_out), .found(found), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] map_word(int lv, int idx);
    case (lv)
      0: map_word = used_map[idx];
      1: map_word = l1_map[idx];
      2: map_word = l2_map[idx];
      default: map_word = top_map;
    endcase
  endfunction

  function automatic void set_map_bit(int lv, int idx, int b);
    case (lv)
      0: used_map[idx][b] = 1'b1;
      1: l1_map[idx][b] = 1'b1;
      2: l2_map[idx][b] = 1'b1;
      default: top_map[b] = 1'b1;
    endcase
  endfunction

  function automatic void propagate_fill(logic [15:0] slot);
    int lv;
    int idx;
    for (lv = 0; lv < 4; lv++) begin
      idx = int'(slot) >> (4 * (lv + 1));
      set_map_bit(lv, idx, (int'(slot) >> (4 * lv)) & 15);
      if (map_word(lv, idx) != 16'hffff) break;
    end
  endfunction

  function automatic rsp_t allocate(logic [1:0] k, logic [15:0] i, logic [31:0] d);
    rsp_t r;
    int prefix;
    int lv;
    int b;
    logic [15:0] w;
    r = '{new_id: i, data_out: '0, found: 1'b0, status: ST_OK};
    case (k)
      KIND_INSERT: begin
        if (top_map == 16'hffff) begin
          r.status = ST_FULL;
        end else begin
          prefix = 0;
          for (lv = 3; lv >= 0; lv--) begin
            w = map_word(lv, prefix);
            b = 0;
            while (b < 15 && w[b]) b++;
            prefix = (prefix << 4) | b;
          end
          r.new_id = prefix[15:0];
          slot_word[prefix] = d;
          propagate_fill(prefix[15:0]);
        end
      end
      KIND_REPLACE: begin
        if (used_map[i[15:4]][i[3:0]]) begin
          r.found = 1'b1;
          r.data_out = slot_word[i];
        end
        slot_word[i] = d;
        if (!r.found) propagate_fill(i);
      end
      KIND_GET: begin
        if (used_map[i[15:4]][i[3:0]]) begin
          r.found = 1'b1;
          r.data_out = slot_word[i];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: bursts with gaps, prediction at each accepted transfer
  int burst_left = 0;

  task automatic send(logic [1:0] k, logic [15:0] i, logic [31:0] d, bit typed, rsp_t t);
    rsp_t r;
    if (!fast && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    req_valid <= 1'b1;
    kind <= k;
    id <= i;
    data_in <= d;
    do @(posedge clk); while (req_stall);
    r = allocate(k, i, d);
    pending_rsp.push_back(typed ? t : r);
    n_sent++;
  endtask

  // receiver: stall pattern redrawn at random among four modes, off in the fast burst
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (fast || stall_mode == 0) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 9) < stall_mode * 3);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** hierarchical_id_allocator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rcvd++;
      if (pending_rsp.size() == 0) begin
        $error("response transfer with nothing outstanding");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (found) n_hits++;
        if (status) n_full++;
        if (new_id !== e.new_id) begin
          $error("new_id expected %h actual %h", e.new_id, new_id);
          errors++;
        end
        if (data_out !== e.data_out) begin
          $error("data_out expected %h actual %h", e.data_out, data_out);
          errors++;
        end
        if (found !== e.found) begin
          $error("found expected %b actual %b", e.found, found);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %b actual %b", e.status, status);
          errors++;
        end
      end
    end
  end

  row_t dir_rows [$];

  function automatic row_t mk(logic [1:0] k, logic [15:0] i, logic [31:0] d, bit ty,
                              logic [15:0] ni, logic [31:0] dout, logic f, logic s);
    row_t r;
    r.kind = k; r.id = i; r.data = d; r.typed = ty;
    r.rsp = '{new_id: ni, data_out: dout, found: f, status: s};
    return r;
  endfunction

  function automatic logic [15:0] pick_id(int frontier);
    case ($urandom_range(0, 5))
      0: pick_id = 16'($urandom_range(0, 65535));
      1: pick_id = 16'(16'hffff - $urandom_range(0, 15));
      2: pick_id = 16'(frontier + $urandom_range(0, 40));
      default: pick_id = 16'($urandom_range(0, frontier + 16));
    endcase
  endfunction

  initial begin
    int n;
    int k;
    int frontier;
    logic [1:0] kk;
    for (n = 0; n < 4096; n++) used_map[n] = '0;
    for (n = 0; n < 256; n++) l1_map[n] = '0;
    for (n = 0; n < 16; n++) l2_map[n] = '0;
    top_map = '0;

    dir_rows.push_back(mk(KIND_GET, 16'h0000, 32'h0, 1, 16'h0000, 32'h0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_INSERT, 16'hffff, 32'h0, 1, 16'h0000, 32'h0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_INSERT, 16'h1234, 32'hffffffff, 1, 16'h0001, 32'h0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_GET, 16'h0001, 32'h0, 1, 16'h0001, 32'hffffffff, 1'b1, ST_OK));
    dir_rows.push_back(mk(KIND_REPLACE, 16'hffff, 32'hffffffff, 1, 16'hffff, 32'h0, 1'b0,
                          ST_OK));
    dir_rows.push_back(mk(KIND_REPLACE, 16'hffff, 32'h0, 1, 16'hffff, 32'hffffffff, 1'b1,
                          ST_OK));
    dir_rows.push_back(mk(KIND_GET, 16'hffff, 32'h5a5a5a5a, 1, 16'hffff, 32'h0, 1'b1, ST_OK));
    dir_rows.push_back(mk(KIND_NONE, 16'hbeef, 32'hffffffff, 1, 16'hbeef, 32'h0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_GET, 16'h8000, 32'h0, 1, 16'h8000, 32'h0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_REPLACE, 16'h0002, 32'h12345678, 0, '0, '0, 1'b0, ST_OK));
    for (n = 0; n < 14; n++)
      dir_rows.push_back(mk(KIND_INSERT, 16'($urandom), $urandom, 0, '0, '0, 1'b0, ST_OK));
    dir_rows.push_back(mk(KIND_GET, 16'h000f, 32'h0, 0, '0, '0, 1'b0, ST_OK));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      send(dir_rows[r].kind, dir_rows[r].id, dir_rows[r].data, dir_rows[r].typed,
           dir_rows[r].rsp);

    frontier = 16;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        req_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(posedge clk);
      end
      k = $urandom_range(0, 19);
      kk = (k < 9) ? KIND_INSERT : (k < 14) ? KIND_REPLACE : (k < 19) ? KIND_GET : KIND_NONE;
      if (kk == KIND_INSERT) frontier++;
      send(kk, pick_id(frontier), $urandom, 0, '0);
    end

    // closing burst with no idling and no receiver stalls
    req_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    fast = 1'b1;
    for (n = 0; n < 6; n++) begin
      send(KIND_INSERT, 16'($urandom), $urandom, 0, '0);
      send(KIND_REPLACE, 16'($urandom), $urandom, 0, '0);
      send(KIND_GET, 16'($urandom), 32'h0, 0, '0);
    end
    fast = 1'b0;
    req_valid <= 1'b0;

    wait (pending_rsp.size() == 0);
    repeat (40) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      errors++;
    end
    $display("%0d requests, %0d responses; %0d found, %0d inserts refused on a full tree",
             n_sent, n_rcvd, n_hits, n_full);
    $display("directed table, random mix with idling and stalls, closing gapless burst");
    if (errors == 0) begin
      $display("** hierarchical_id_allocator: PASSED **");
    end else begin
      $display("** hierarchical_id_allocator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
